### design/cdhu_pkg.sv
// ----------------------------------------------------------------------------
// cdhu_pkg
// Shared types, constants and helpers for the cpu debug halt unit.
// ----------------------------------------------------------------------------
package cdhu_pkg;

    // breakpoint table geometry
    localparam int BP_SLOTS = 8;
    localparam int CNT_W    = $clog2(BP_SLOTS + 1);
    localparam int ADDR_W   = 16;

    // stream payload widths
    localparam int IN_DATA_W  = 64;
    localparam int IN_USER_W  = 4;
    localparam int OUT_DATA_W = 48;

    // opcode bytes used by step over
    localparam logic [7:0] CALL_OP    = 8'hCD;
    localparam logic [7:0] GROUP_MASK = 8'hC7;
    localparam logic [7:0] CCALL_PAT  = 8'hC4;
    localparam logic [7:0] RST_PAT    = 8'hC7;
    localparam logic [7:0] DJNZ_OP    = 8'h10;
    localparam logic [7:0] ED_PREFIX  = 8'hED;

    typedef enum logic [1:0] {
        MODE_RUN       = 2'd0,
        MODE_STEP      = 2'd1,
        MODE_PAUSE_REQ = 2'd2,
        MODE_PAUSED    = 2'd3
    } t_mode;

    typedef enum logic [3:0] {
        OP_BOUNDARY  = 4'd0,
        OP_PAUSE     = 4'd1,
        OP_RESUME    = 4'd2,
        OP_STEP      = 4'd3,
        OP_STEP_OVER = 4'd4,
        OP_STEP_OUT  = 4'd5,
        OP_TOGGLE    = 4'd6,
        OP_CLEAR_ALL = 4'd7,
        OP_QUERY     = 4'd8
    } t_opcode;

    typedef enum logic [1:0] {
        TOG_NONE    = 2'd0,
        TOG_REMOVED = 2'd1,
        TOG_ADDED   = 2'd2,
        TOG_FULL    = 2'd3
    } t_tog;

    // per-request table update, broadcast to every cell
    typedef struct packed {
        logic add;
        logic remove;
    } t_cell_ctl;

    // opcodes that step over runs past instead of into
    function automatic logic f_step_over_op(input logic [7:0] b);
        logic call_like;
        call_like = (b == CALL_OP) || ((b & GROUP_MASK) == CCALL_PAT) ||
                    ((b & GROUP_MASK) == RST_PAT) || (b == DJNZ_OP);
        return call_like || (b == ED_PREFIX);
    endfunction

endpackage

### design/cdhu_bp_cell.sv
// ----------------------------------------------------------------------------
// cdhu_bp_cell
// One breakpoint slot: holds an address, compares it and passes the
// match-so-far flag and its entry to the neighbors for compaction.
// ----------------------------------------------------------------------------
module cdhu_bp_cell (
    input  logic                          i_clk,
    input  cdhu_pkg::t_cell_ctl           i_ctl,
    input  logic [cdhu_pkg::ADDR_W-1:0]   i_addr,
    input  logic                          i_live,
    input  logic                          i_tail,
    input  logic                          i_next_live,
    input  logic [cdhu_pkg::ADDR_W-1:0]   i_next_entry,
    input  logic                          i_hit_prev,
    output logic                          o_hit,
    output logic [cdhu_pkg::ADDR_W-1:0]   o_entry
);

    logic [cdhu_pkg::ADDR_W-1:0] r_entry;
    logic                        w_match;

    // compare against the request address
    assign w_match = i_live && (r_entry == i_addr);
    assign o_hit   = i_hit_prev | w_match;
    assign o_entry = r_entry;

    // add at the tail, or close the gap left by a removed entry
    always_ff @(posedge i_clk) begin
        if (i_ctl.add && i_tail) begin
            r_entry <= i_addr;
        end else if (i_ctl.remove && o_hit && i_next_live) begin
            r_entry <= i_next_entry;
        end
    end

endmodule

### design/cpu_debug_halt_unit_core.sv
// ----------------------------------------------------------------------------
// cpu_debug_halt_unit_core
// Debug halt controller with a breakpoint table built as a row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_axis channel: the command kind rides on tuser,
//   the PC, SP, target address, opcode byte and length on tdata. Every
//   request gives exactly one response on m_axis carrying the halt flag,
//   the paused flag, toggle and query status, the stop count and the
//   number of breakpoints in use.
//   The response is registered, so m_axis_tvalid rises in the cycle after the
//   accepting edge, and one request is taken per cycle while the output
//   register is empty or its response is leaving. The compare of the request
//   address across the whole cell row is combinational; its match flag ripples from cell to cell.
//   The response sits in an output register; a new request is taken in the
//   same cycle the waiting response leaves, so a stalled receiver holds
//   the response and backs up s_axis_tready only while it is full.
//   Reset puts the unit in run mode with an empty table, no one-shot, no
//   guard and a zero stop count; no clearing pass is needed.
// ----------------------------------------------------------------------------
module cpu_debug_halt_unit_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // cpu_pc, stack_pointer, target_address, instruction_byte,
    // instruction_length, zero pad
    input  logic [cdhu_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // opcode
    input  logic [cdhu_pkg::IN_USER_W-1:0]    s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // stopped_now, is_paused, toggle_status, breakpoint_present,
    // stop_total, breakpoints_in_use, zero pad
    output logic [cdhu_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

    localparam int SLOTS = cdhu_pkg::BP_SLOTS;
    localparam int CW    = cdhu_pkg::CNT_W;
    localparam int AW    = cdhu_pkg::ADDR_W;

    // request fields
    logic [AW-1:0]       w_pc, w_sp, w_target;
    logic [7:0]          w_ibyte;
    logic [2:0]          w_ilen;
    cdhu_pkg::t_opcode   w_op;
    logic                w_acc;
    logic                r_out_valid;

    assign w_pc     = s_axis_tdata[15:0];
    assign w_sp     = s_axis_tdata[31:16];
    assign w_target = s_axis_tdata[47:32];
    assign w_ibyte  = s_axis_tdata[55:48];
    assign w_ilen   = s_axis_tdata[58:56];
    assign w_op     = cdhu_pkg::t_opcode'(s_axis_tuser);

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_acc         = s_axis_tvalid && s_axis_tready;

    // control state
    cdhu_pkg::t_mode     r_mode, n_mode;
    logic [CW-1:0]       r_count, n_count;
    logic                r_os_armed, n_os_armed;
    logic [AW-1:0]       r_os_addr, n_os_addr;
    logic                r_guard_armed, n_guard_armed;
    logic [AW-1:0]       r_guard_lim, n_guard_lim;
    logic [31:0]         r_stops, n_stops;
    logic [AW-1:0]       r_hpc, n_hpc;
    logic [AW-1:0]       r_hsp, n_hsp;
    logic                r_seen, n_seen;

    // response register
    logic                r_o_stopped, n_o_stopped;
    cdhu_pkg::t_tog      r_o_tog, n_o_tog;
    logic                r_o_present, n_o_present;

    // cell row
    cdhu_pkg::t_cell_ctl w_ctl;
    logic [AW-1:0]       w_cmp_addr;
    logic [SLOTS:0]      w_hit;
    logic [AW-1:0]       w_entry [SLOTS];
    logic                w_any_hit;
    logic                w_stop;
    logic [AW-1:0]       w_step_len;

    assign w_cmp_addr = (w_op == cdhu_pkg::OP_BOUNDARY) ? w_pc : w_target;
    assign w_hit[0]   = 1'b0;
    assign w_any_hit  = w_hit[SLOTS];

    genvar g;
    generate
        for (g = 0; g < SLOTS; g++) begin : g_cell
            logic          w_next_live;
            logic [AW-1:0] w_next_entry;
            if (g == SLOTS - 1) begin : g_last
                assign w_next_live  = 1'b0;
                assign w_next_entry = '0;
            end else begin : g_mid
                assign w_next_live  = r_count > CW'(g + 1);
                assign w_next_entry = w_entry[g + 1];
            end
            cdhu_bp_cell u_cell (
                .i_clk        (i_clk),
                .i_ctl        (w_ctl),
                .i_addr       (w_cmp_addr),
                .i_live       (r_count > CW'(g)),
                .i_tail       (r_count == CW'(g)),
                .i_next_live  (w_next_live),
                .i_next_entry (w_next_entry),
                .i_hit_prev   (w_hit[g]),
                .o_hit        (w_hit[g + 1]),
                .o_entry      (w_entry[g])
            );
        end
    endgenerate

    // halt condition at a boundary
    assign w_stop = (r_mode == cdhu_pkg::MODE_PAUSE_REQ) || (r_mode == cdhu_pkg::MODE_STEP) ||
                    w_any_hit ||
                    (r_os_armed && (w_pc == r_os_addr) &&
                     (!r_guard_armed || (w_sp >= r_guard_lim)));
    assign w_step_len = (w_ilen == 3'd0) ? AW'(1) : AW'(w_ilen);

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= cdhu_pkg::MODE_RUN;
            r_count       <= '0;
            r_os_armed    <= 1'b0;
            r_os_addr     <= '0;
            r_guard_armed <= 1'b0;
            r_guard_lim   <= '0;
            r_stops       <= '0;
            r_hpc         <= '0;
            r_hsp         <= '0;
            r_seen        <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_mode        <= n_mode;
            r_count       <= n_count;
            r_os_armed    <= n_os_armed;
            r_os_addr     <= n_os_addr;
            r_guard_armed <= n_guard_armed;
            r_guard_lim   <= n_guard_lim;
            r_stops       <= n_stops;
            r_hpc         <= n_hpc;
            r_hsp         <= n_hsp;
            r_seen        <= n_seen;
            r_out_valid   <= w_acc || (r_out_valid && !m_axis_tready);
        end
    end

    // response payload
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_o_stopped <= n_o_stopped;
            r_o_tog     <= n_o_tog;
            r_o_present <= n_o_present;
        end
    end

    // next state and table control per request
    always_comb begin
        n_mode        = r_mode;
        n_count       = r_count;
        n_os_armed    = r_os_armed;
        n_os_addr     = r_os_addr;
        n_guard_armed = r_guard_armed;
        n_guard_lim   = r_guard_lim;
        n_stops       = r_stops;
        n_hpc         = r_hpc;
        n_hsp         = r_hsp;
        n_seen        = r_seen;
        n_o_stopped   = 1'b0;
        n_o_tog       = cdhu_pkg::TOG_NONE;
        n_o_present   = 1'b0;
        w_ctl         = '0;
        if (w_acc) begin
            case (w_op)
                cdhu_pkg::OP_BOUNDARY: begin
                    n_seen = 1'b1;
                    if (r_mode != cdhu_pkg::MODE_PAUSED && w_stop) begin
                        n_os_armed    = 1'b0;
                        n_guard_armed = 1'b0;
                        n_mode        = cdhu_pkg::MODE_PAUSED;
                        n_stops       = r_stops + 32'd1;
                        n_hpc         = w_pc;
                        n_hsp         = w_sp;
                        n_o_stopped   = 1'b1;
                    end
                end
                cdhu_pkg::OP_PAUSE: begin
                    if (r_mode != cdhu_pkg::MODE_PAUSED) begin
                        n_mode = cdhu_pkg::MODE_PAUSE_REQ;
                    end
                end
                cdhu_pkg::OP_RESUME: begin
                    n_mode = cdhu_pkg::MODE_RUN;
                end
                cdhu_pkg::OP_STEP: begin
                    if (r_mode == cdhu_pkg::MODE_PAUSED) begin
                        n_mode = cdhu_pkg::MODE_STEP;
                    end
                end
                cdhu_pkg::OP_STEP_OVER: begin
                    if (r_mode == cdhu_pkg::MODE_PAUSED) begin
                        if (r_seen && cdhu_pkg::f_step_over_op(w_ibyte)) begin
                            n_os_armed    = 1'b1;
                            n_os_addr     = r_hpc + w_step_len;
                            n_guard_armed = 1'b0;
                            n_mode        = cdhu_pkg::MODE_RUN;
                        end else begin
                            n_mode = cdhu_pkg::MODE_STEP;
                        end
                    end
                end
                cdhu_pkg::OP_STEP_OUT: begin
                    if (r_mode == cdhu_pkg::MODE_PAUSED && r_seen) begin
                        n_os_armed    = 1'b1;
                        n_os_addr     = w_target;
                        n_guard_armed = 1'b1;
                        n_guard_lim   = r_hsp + AW'(2);
                        n_mode        = cdhu_pkg::MODE_RUN;
                    end
                end
                cdhu_pkg::OP_TOGGLE: begin
                    if (w_any_hit) begin
                        w_ctl.remove = 1'b1;
                        n_count      = r_count - CW'(1);
                        n_o_tog      = cdhu_pkg::TOG_REMOVED;
                    end else if (r_count < CW'(SLOTS)) begin
                        w_ctl.add = 1'b1;
                        n_count   = r_count + CW'(1);
                        n_o_tog   = cdhu_pkg::TOG_ADDED;
                    end else begin
                        n_o_tog = cdhu_pkg::TOG_FULL;
                    end
                end
                cdhu_pkg::OP_CLEAR_ALL: begin
                    n_count = '0;
                end
                cdhu_pkg::OP_QUERY: begin
                    n_o_present = w_any_hit;
                end
                default: begin
                end
            endcase
        end
    end

    // response bus
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, 4'(r_count), r_stops, r_o_present, r_o_tog,
                            (r_mode == cdhu_pkg::MODE_PAUSED), r_o_stopped};

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(SLOTS))
        else $error("breakpoint count above table size");

    a_guard_needs_oneshot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_guard_armed |-> r_os_armed)
        else $error("stack guard armed without one-shot");

    a_halt_pauses: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_o_stopped) |-> (r_mode == cdhu_pkg::MODE_PAUSED))
        else $error("halt reported while not paused");

    a_halt_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && n_o_stopped) |=> (r_stops == $past(r_stops) + 32'd1) && !r_os_armed)
        else $error("halt did not count or clear one-shot");

    a_ctl_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_ctl.add, w_ctl.remove}))
        else $error("table add and remove in one request");

endmodule
